/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

/* rtl/fmmp_pkg.sv */
// ----------------------------------------------------------------------------
// fmmp_pkg
// Widths, types and the modular add shared by the Fibonacci matrix unit.
// ----------------------------------------------------------------------------
package fmmp_pkg;

  localparam int IDX_FIELD_W = 64;
  localparam int MOD_FIELD_W = 32;
  localparam int INDEX_BITS  = 64;
  localparam int MOD_BITS    = 32;

  localparam int IDX_CNT_W = $clog2(INDEX_BITS);
  localparam int MUL_CNT_W = $clog2(MOD_BITS + 1);

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [MOD_BITS-1:0]   mod_t;

  localparam mod_t MOD_ONE = mod_t'(1);

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

  // (a + b) mod m for a, b < m
  function automatic mod_t add_mod(mod_t a, mod_t b, mod_t m);
    logic [MOD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[MOD_BITS-1:0];
  endfunction

endpackage

/* rtl/fmmp_mulmod.sv */
// ----------------------------------------------------------------------------
// fmmp_mulmod
// Bit-serial modular multiplier: x * y mod m, one bit of y per cycle, MSB first.
// ----------------------------------------------------------------------------
module fmmp_mulmod import fmmp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  mod_t x,
  input  mod_t y,
  input  mod_t m,
  output logic busy,
  output mod_t prod
);

  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  mod_t x_r, x_nxt;
  mod_t y_r, y_nxt;
  mod_t r_r, r_nxt;

  logic [MOD_BITS:0] m_ext, dbl, dbl_red, sum, sum_red;

  assign busy = (cnt_r != '0);
  assign prod = r_r;

  always_comb begin
    m_ext   = {1'b0, m};
    dbl     = {r_r, 1'b0};
    dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum     = dbl_red + (y_r[MOD_BITS-1] ? {1'b0, x_r} : '0);
    sum_red = (sum >= m_ext) ? sum - m_ext : sum;

    cnt_nxt = cnt_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    r_nxt   = r_r;
    if (start) begin
      cnt_nxt = MUL_CNT_W'(MOD_BITS);
      x_nxt   = x;
      y_nxt   = y;
      r_nxt   = '0;
    end else if (busy) begin
      cnt_nxt = cnt_r - MUL_CNT_W'(1);
      y_nxt   = y_r << 1;
      r_nxt   = sum_red[MOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    r_r <= r_nxt;
  end

endmodule

/* rtl/fmmp_core.sv */
// ----------------------------------------------------------------------------
// fmmp_core
// Square-and-multiply sequencer over the index bits with four multiplier lanes.
// ----------------------------------------------------------------------------
module fmmp_core import fmmp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  idx_t       index,
  input  mod_t       modulus,
  input  logic       take,
  output core_stat_t stat,
  output mod_t       result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_QS   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [IDX_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  idx_t                 n_r, n_nxt;
  mod_t                 m_r, m_nxt;
  // power of Q is symmetric: [[a, b], [b, c]]
  mod_t                 a_r, a_nxt;
  mod_t                 b_r, b_nxt;
  mod_t                 c_r, c_nxt;

  logic       lane_start;
  logic [3:0] lane_busy;
  mod_t       lane_x [4];
  mod_t       lane_y [4];
  mod_t       lane_p [4];
  mod_t       one_v;

  assign lane_start = (state_r == S_PREP);
  assign lane_x[0] = a_r;
  assign lane_y[0] = a_r;
  assign lane_x[1] = b_r;
  assign lane_y[1] = b_r;
  assign lane_x[2] = c_r;
  assign lane_y[2] = c_r;
  assign lane_x[3] = b_r;
  assign lane_y[3] = add_mod(a_r, c_r, m_r);

  for (genvar g = 0; g < 4; g++) begin : g_lane
    fmmp_mulmod u_mul (
      .clk   (clk),
      .rst_n (rst_n),
      .start (lane_start),
      .x     (lane_x[g]),
      .y     (lane_y[g]),
      .m     (m_r),
      .busy  (lane_busy[g]),
      .prod  (lane_p[g])
    );
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE);
  assign result    = b_r;
  assign one_v     = (modulus == MOD_ONE) ? '0 : MOD_ONE;

  always_comb begin
    state_nxt   = state_r;
    bit_cnt_nxt = bit_cnt_r;
    n_nxt       = n_r;
    m_nxt       = m_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    c_nxt       = c_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          m_nxt       = modulus;
          n_nxt       = index;
          bit_cnt_nxt = IDX_CNT_W'(INDEX_BITS - 1);
          a_nxt       = one_v;
          b_nxt       = '0;
          c_nxt       = one_v;
          state_nxt   = (modulus == '0) ? S_DONE : S_PREP;
        end
      end
      S_PREP: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (lane_busy == '0) begin
          a_nxt     = add_mod(lane_p[0], lane_p[1], m_r);
          b_nxt     = lane_p[3];
          c_nxt     = add_mod(lane_p[1], lane_p[2], m_r);
          state_nxt = S_QS;
        end
      end
      S_QS: begin
        if (n_r[INDEX_BITS-1]) begin
          a_nxt = add_mod(a_r, b_r, m_r);
          b_nxt = a_r;
          c_nxt = b_r;
        end
        n_nxt = n_r << 1;
        if (bit_cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          bit_cnt_nxt = bit_cnt_r - IDX_CNT_W'(1);
          state_nxt   = S_PREP;
        end
      end
      S_DONE: begin
        if (take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_cnt_r <= bit_cnt_nxt;
    n_r       <= n_nxt;
    m_r       <= m_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    c_r       <= c_nxt;
  end

endmodule

/* rtl/fibonacci_mod_matrix_power_unit.sv */
// ----------------------------------------------------------------------------
// fibonacci_mod_matrix_power_unit
// F(n) mod m by 2x2 matrix square-and-multiply with bit-serial modular products.
// ----------------------------------------------------------------------------
// Input channel in_valid / in_stall carries one request: in_fib_index (n) and
// in_modulus (m). The result leaves on out_valid / out_stall as out_fib_mod.
// A request is taken when valid is high and stall is low.
// One request is in work at a time; every index bit costs one pass of the
// four bit-serial modular multipliers plus a square update and Q step.
// A modulus of zero answers 0 without a multiplier pass. The core returns to
// idle once its result moves into the output register, and only then takes
// the next request.
// The result sits in an output register; while it waits the next request is
// already accepted and worked on. A finished result held back by out_stall
// keeps the core in its done state and in_stall high until the slot frees.
// Synchronous active-low reset empties the output register and returns the
// sequencer to idle; the request in work, if any, is dropped.
// ----------------------------------------------------------------------------
module fibonacci_mod_matrix_power_unit import fmmp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [IDX_FIELD_W-1:0] in_fib_index,
  input  logic [MOD_FIELD_W-1:0] in_modulus,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [MOD_FIELD_W-1:0] out_fib_mod
);

  core_stat_t stat;
  mod_t       core_result;
  logic       out_free;
  logic       out_valid_r, out_valid_nxt;
  logic [MOD_FIELD_W-1:0] out_data_r, out_data_nxt;

  assign in_stall = !stat.idle;
  assign out_free = !out_valid_r || !out_stall;

  fmmp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_valid && !in_stall),
    .index   (in_fib_index[INDEX_BITS-1:0]),
    .modulus (in_modulus[MOD_BITS-1:0]),
    .take    (out_free),
    .stat    (stat),
    .result  (core_result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (stat.done && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = MOD_FIELD_W'(core_result);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_fib_mod = out_data_r;

endmodule

/* rtl/fmmp_checker.sv */
// ----------------------------------------------------------------------------
// fmmp_checker
// Port-level checks on request flow of the Fibonacci matrix unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fmmp_checker import fmmp_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [MOD_FIELD_W-1:0] out_fib_mod
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r, pend_nxt;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) pend_nxt = pend_r + 2'd1;
    else if (!in_acc && out_acc) pend_nxt = pend_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_fib_mod))
  `ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_acc, in_stall)
  `ASSERT_IMPLIES(a_pend_limit, clk, rst_n, 1'b1, pend_r != 2'd3)
  `ASSERT_IMPLIES(a_no_phantom, clk, rst_n, out_valid, pend_r != 2'd0)

endmodule

bind fibonacci_mod_matrix_power_unit fmmp_checker u_fmmp_checker (.*);

/* tb/sv/tb_fibonacci_mod_matrix_power_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fibonacci_mod_matrix_power_unit
// Drives index / modulus requests with random gaps and result stalls, predicts
// F(n) mod m by its own 2x2 matrix square-and-multiply and checks each result
// in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_fibonacci_mod_matrix_power_unit;
  import fmmp_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [IDX_FIELD_W-1:0] in_fib_index;
  logic [MOD_FIELD_W-1:0] in_modulus;
  logic                   out_valid;
  logic                   out_stall;
  logic [MOD_FIELD_W-1:0] out_fib_mod;

  fibonacci_mod_matrix_power_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_fib_index (in_fib_index),
    .in_modulus   (in_modulus),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_fib_mod  (out_fib_mod)
  );

  typedef struct packed {
    logic [63:0] e00;
    logic [63:0] e01;
    logic [63:0] e10;
    logic [63:0] e11;
  } mat2_t;

  typedef struct {
    logic [IDX_FIELD_W-1:0] n;
    logic [MOD_FIELD_W-1:0] m;
    mod_t                   fib;
  } fib_req_t;

  class fib_mod_scoreboard;
    fib_req_t pending_fib[$];
    int       errors = 0;

    // entries are below m < 2^32, so each product fits in 64 bits
    function automatic mat2_t mat_prod(mat2_t x, mat2_t y, logic [63:0] mm);
      mat2_t r;
      r.e00 = ((x.e00 * y.e00) % mm + (x.e01 * y.e10) % mm) % mm;
      r.e01 = ((x.e00 * y.e01) % mm + (x.e01 * y.e11) % mm) % mm;
      r.e10 = ((x.e10 * y.e00) % mm + (x.e11 * y.e10) % mm) % mm;
      r.e11 = ((x.e10 * y.e01) % mm + (x.e11 * y.e11) % mm) % mm;
      return r;
    endfunction

    function automatic mod_t fib_mod_predict(idx_t n, mod_t m);
      logic [63:0] mm;
      mat2_t       q;
      mat2_t       acc;
      if (m == '0) return '0;
      mm  = 64'(m);
      q   = '{e00: 64'd1 % mm, e01: 64'd1 % mm, e10: 64'd1 % mm, e11: 64'd0};
      acc = '{e00: 64'd1 % mm, e01: 64'd0, e10: 64'd0, e11: 64'd1 % mm};
      for (int b = INDEX_BITS - 1; b >= 0; b--) begin
        acc = mat_prod(acc, acc, mm);
        if (n[b]) acc = mat_prod(acc, q, mm);
      end
      return mod_t'(acc.e01);
    endfunction

    function void note_request(logic [IDX_FIELD_W-1:0] n, logic [MOD_FIELD_W-1:0] m);
      fib_req_t r;
      r.n   = n;
      r.m   = m;
      r.fib = fib_mod_predict(idx_t'(n), mod_t'(m));
      pending_fib.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_result(logic [MOD_FIELD_W-1:0] got);
      fib_req_t r;
      if (pending_fib.size() == 0) begin
        report($sformatf("unexpected result fib_mod=%0d", got));
      end else begin
        r = pending_fib.pop_front();
        if (got !== MOD_FIELD_W'(r.fib))
          report($sformatf("n=%0d m=%0d fib_mod got %0d exp %0d", r.n, r.m, got, r.fib));
      end
    endtask
  endclass

  fib_mod_scoreboard sb = new();
  bit in_burst;
  bit out_burst;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_fib_index, in_modulus);
      if (out_valid && !out_stall) sb.check_result(out_fib_mod);
    end
  end

  task automatic send_request(input logic [IDX_FIELD_W-1:0] n,
                              input logic [MOD_FIELD_W-1:0] m);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_fib_index <= n;
    in_modulus   <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_fib.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_request();
    logic [IDX_FIELD_W-1:0] n;
    logic [MOD_FIELD_W-1:0] m;
    int                     kind;
    kind = $urandom_range(0, 99);
    n    = {$urandom, $urandom} >> $urandom_range(0, 63);
    m    = $urandom >> $urandom_range(0, 31);
    if (kind < 60) begin
      n = {$urandom, $urandom};
      m = $urandom;
    end else if (kind < 75) begin
      n = IDX_FIELD_W'($urandom_range(0, 200));
    end else if (kind < 88) begin
      m = $urandom_range(1, 16);
    end else if (kind < 94) begin
      m = '0;
    end
    send_request(n, m);
  endtask

  // receiver: random stall run before each result, with stall-free stretches
  initial begin
    int k;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      k = out_burst ? 0 : $urandom_range(0, 13);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #160_000_000;
    $display("tb_fibonacci_mod_matrix_power_unit failed");
    $finish;
  end

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_fib_index <= '0;
    in_modulus   <= '0;
    in_burst      = 1'b0;
    out_burst     = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: small indices, modulus one and zero, extreme operands
    send_request(64'd0, 32'd5);
    send_request(64'd0, 32'd1);
    send_request(64'd1, 32'd1);
    send_request(64'd1, 32'd7);
    send_request(64'd2, 32'hFFFF_FFFF);
    send_request(64'd10, 32'd1000);
    send_request(64'd12, 32'd144);
    send_request(64'd93, 32'hFFFF_FFFF);
    send_request(64'd0, 32'd0);
    send_request(64'd1, 32'd0);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 32'd2);
    send_request(64'h8000_0000_0000_0000, 32'h8000_0000);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
    send_request(64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
    send_request(64'd100, 32'd1);
    send_request(64'd3, 32'hFFFF_FFFE);
    drain_results();

    // random phases with randomly chosen burst patterns; every third phase drains fully
    for (int ph = 0; ph < 13; ph++) begin
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 49; i++) send_random_request();
      if (ph % 3 == 0) drain_results();
    end
    in_valid <= 1'b0;

    while (sb.pending_fib.size() != 0) @(posedge clk);
    repeat (2300) @(posedge clk);

    if (sb.errors == 0 && sb.pending_fib.size() == 0) begin
      $display("tb_fibonacci_mod_matrix_power_unit passed");
    end else begin
      $display("tb_fibonacci_mod_matrix_power_unit failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/fmmp_pkg.sv
rtl/fmmp_mulmod.sv
rtl/fmmp_core.sv
rtl/fibonacci_mod_matrix_power_unit.sv
rtl/fmmp_checker.sv
tb/sv/tb_fibonacci_mod_matrix_power_unit.sv
